### rtl/scl_pkg.sv
// Shared types and constants for the command line lexer.
// No dependencies; every other file but scl_if.sv imports this package.
package scl_pkg;

  // result slots produced for one input character
  localparam int MAX_RESULTS = 5;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] TOK_LIMIT_RST = 8'd128;

  // operator codes
  localparam logic [2:0] OP_AND_AND = 3'd0;
  localparam logic [2:0] OP_OR_OR   = 3'd1;
  localparam logic [2:0] OP_APPEND  = 3'd2;
  localparam logic [2:0] OP_SEMI    = 3'd3;
  localparam logic [2:0] OP_PIPE    = 3'd4;
  localparam logic [2:0] OP_GT      = 3'd5;
  localparam logic [2:0] OP_LT      = 3'd6;

  // special characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_WEND = 2'd1,
    KIND_OP   = 2'd2,
    KIND_DONE = 2'd3
  } kind_e;

  // first operator character waiting for its twin
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_AMP  = 2'd1,
    HELD_BAR  = 2'd2,
    HELD_GT   = 2'd3
  } held_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] word_byte;
    logic [2:0] operator_code;
    logic [7:0] token_total;
    logic       last_result;
  } result_t;

  // all results of one input character
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [RES_CNT_W-1:0]      count;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### rtl/scl_if.sv
// Channel interfaces of the command line lexer: input characters,
// result tokens and the token limit configuration write. No dependencies.
interface scl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_line;
  modport source (output valid, character, end_of_line, input ready);
  modport sink   (input valid, character, end_of_line, output ready);
endinterface

interface scl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] word_byte;
  logic [2:0] operator_code;
  logic [7:0] token_total;
  logic       last_result;
  modport source (output valid, kind, word_byte, operator_code, token_total, last_result,
                  input ready);
  modport sink   (input valid, kind, word_byte, operator_code, token_total, last_result,
                  output ready);
endinterface

interface scl_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] tok_limit;
  modport source (output valid, tok_limit, input ready);
  modport sink   (input valid, tok_limit, output ready);
endinterface

### rtl/shell_command_lexer.sv
// Shell command line lexer, top level. The results of an accepted character
// pass through the bundle queue and then the output register. One character
// a cycle while the 4-entry bundle queue has room; a character that causes
// n results holds the single output register until all n have left it.
// Reset: lexer state clears at once, the token limit register returns to 128.
module shell_command_lexer #(
  parameter int LINE_BUFFER_LEN = 1024,
  parameter int TOKEN_LIMIT     = 128,
  parameter int FIFO_DEPTH      = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scl_in_if.sink    in_i,
  scl_cfg_if.sink   cfg_i,
  scl_out_if.source out_o
);
  import scl_pkg::*;

  logic       push, pop;
  bundle_t    push_data, head;
  fifo_stat_t stat;

  scl_front #(
    .LINE_BUFFER_LEN(LINE_BUFFER_LEN),
    .TOKEN_LIMIT    (TOKEN_LIMIT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .stat_i  (stat),
    .push_o  (push),
    .bundle_o(push_data)
  );

  scl_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (stat)
  );

  scl_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .head_i(head),
    .stat_i(stat),
    .pop_o (pop),
    .out_o (out_o)
  );

endmodule

### rtl/scl_front.sv
// Lexer front end: accepts one character per handshake, updates the lexer state
// and builds the bundle of results it causes. Uses scl_pkg and scl_if.
module scl_front #(
  parameter int LINE_BUFFER_LEN = 1024,
  parameter int TOKEN_LIMIT     = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  scl_in_if.sink            in_i,
  scl_cfg_if.sink           cfg_i,
  input  scl_pkg::fifo_stat_t stat_i,
  output logic              push_o,
  output scl_pkg::bundle_t  bundle_o
);
  import scl_pkg::*;

  localparam int WLW = $clog2(LINE_BUFFER_LEN);
  localparam logic [WLW-1:0] WLEN_CUT = WLW'(LINE_BUFFER_LEN - 1);
  localparam logic [7:0] TOKEN_LIMIT_C = 8'(TOKEN_LIMIT);

  typedef struct packed {
    logic           in_word;
    logic           sq;
    logic           dq;
    logic           esc;
    logic [WLW-1:0] wlen;
    logic [7:0]     tcnt;
    held_e          held;
    logic           redo;
    bundle_t        b;
  } work_t;

  logic           in_word_q, sq_q, dq_q, esc_q;
  logic [WLW-1:0] wlen_q;
  logic [7:0]     tcnt_q;
  held_e          held_q;
  logic [7:0]     tok_limit_q;
  logic [7:0]     lim;
  logic           acc;
  work_t          step;

  // ---- helpers, one per lexer action ----
  function automatic work_t f_emit(work_t w, kind_e k, logic [7:0] wb, logic [2:0] op,
                                   logic [7:0] tot);
    if (w.b.count < RES_CNT_W'(MAX_RESULTS)) begin
      w.b.res[w.b.count[RES_IDX_W-1:0]] = '{kind: k, word_byte: wb, operator_code: op,
                                             token_total: tot, last_result: 1'b0};
      w.b.count = w.b.count + 1'b1;
    end
    return w;
  endfunction

  function automatic logic [7:0] f_bump(logic [7:0] t);
    return (t != 8'hFF) ? t + 8'd1 : t;
  endfunction

  function automatic work_t f_end_word(work_t w);
    w = f_emit(w, KIND_WEND, 8'd0, 3'd0, 8'd0);
    w.tcnt    = f_bump(w.tcnt);
    w.in_word = 1'b0;
    w.sq      = 1'b0;
    w.dq      = 1'b0;
    w.esc     = 1'b0;
    w.wlen    = '0;
    return w;
  endfunction

  function automatic work_t f_put_byte(work_t w, logic [7:0] c);
    w = f_emit(w, KIND_BYTE, c, 3'd0, 8'd0);
    w.wlen = w.wlen + 1'b1;
    if (w.wlen >= WLEN_CUT) w = f_end_word(w);
    return w;
  endfunction

  function automatic work_t f_begin_word(work_t w);
    w.in_word = 1'b1;
    w.sq      = 1'b0;
    w.dq      = 1'b0;
    w.esc     = 1'b0;
    w.wlen    = '0;
    return w;
  endfunction

  function automatic logic f_is_sep(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_SEMI) || (c == CH_BAR) ||
           (c == CH_GT) || (c == CH_LT);
  endfunction

  // character inside a word; redo set when it ended the word
  function automatic work_t f_word_char(work_t w, logic [7:0] c);
    w.redo = 1'b0;
    if (w.esc) begin
      w.esc = 1'b0;
      w = f_put_byte(w, c);
    end else if (!w.sq && !w.dq && f_is_sep(c)) begin
      w = f_end_word(w);
      w.redo = 1'b1;
    end else if (!w.sq && c == CH_DQUOTE) begin
      w.dq = !w.dq;
    end else if (!w.dq && c == CH_SQUOTE) begin
      w.sq = !w.sq;
    end else if (c == CH_BSLASH) begin
      w.esc = 1'b1;
    end else begin
      w = f_put_byte(w, c);
    end
    return w;
  endfunction

  // character at a token start
  function automatic work_t f_start_char(work_t w, logic [7:0] c, logic [7:0] l);
    if (c == CH_SPACE || c == CH_TAB || w.tcnt >= l) begin
      // skipped
    end else if (c == CH_SEMI) begin
      w = f_emit(w, KIND_OP, 8'd0, OP_SEMI, 8'd0);
      w.tcnt = f_bump(w.tcnt);
    end else if (c == CH_LT) begin
      w = f_emit(w, KIND_OP, 8'd0, OP_LT, 8'd0);
      w.tcnt = f_bump(w.tcnt);
    end else if (c == CH_AMP) begin
      w.held = HELD_AMP;
    end else if (c == CH_BAR) begin
      w.held = HELD_BAR;
    end else if (c == CH_GT) begin
      w.held = HELD_GT;
    end else begin
      w = f_begin_word(w);
      w = f_word_char(w, c);
      w.redo = 1'b0;
    end
    return w;
  endfunction

  assign lim = (tok_limit_q > TOKEN_LIMIT_C) ? TOKEN_LIMIT_C : tok_limit_q;

  // ---- next state and results of the offered character ----
  always_comb begin
    step         = '0;
    step.in_word = in_word_q;
    step.sq      = sq_q;
    step.dq      = dq_q;
    step.esc     = esc_q;
    step.wlen    = wlen_q;
    step.tcnt    = tcnt_q;
    step.held    = HELD_NONE;

    unique case (held_q)
      HELD_AMP: begin
        if (in_i.character == CH_AMP) begin
          step = f_emit(step, KIND_OP, 8'd0, OP_AND_AND, 8'd0);
          step.tcnt = f_bump(step.tcnt);
        end else begin
          step = f_begin_word(step);
          step = f_put_byte(step, CH_AMP);
          if (step.in_word) begin
            step = f_word_char(step, in_i.character);
            if (step.redo) step = f_start_char(step, in_i.character, lim);
          end else begin
            step = f_start_char(step, in_i.character, lim);
          end
        end
      end
      HELD_BAR: begin
        if (in_i.character == CH_BAR) begin
          step = f_emit(step, KIND_OP, 8'd0, OP_OR_OR, 8'd0);
          step.tcnt = f_bump(step.tcnt);
        end else begin
          step = f_emit(step, KIND_OP, 8'd0, OP_PIPE, 8'd0);
          step.tcnt = f_bump(step.tcnt);
          step = f_start_char(step, in_i.character, lim);
        end
      end
      HELD_GT: begin
        if (in_i.character == CH_GT) begin
          step = f_emit(step, KIND_OP, 8'd0, OP_APPEND, 8'd0);
          step.tcnt = f_bump(step.tcnt);
        end else begin
          step = f_emit(step, KIND_OP, 8'd0, OP_GT, 8'd0);
          step.tcnt = f_bump(step.tcnt);
          step = f_start_char(step, in_i.character, lim);
        end
      end
      HELD_NONE: begin
        if (step.in_word) begin
          step = f_word_char(step, in_i.character);
          if (step.redo) step = f_start_char(step, in_i.character, lim);
        end else begin
          step = f_start_char(step, in_i.character, lim);
        end
      end
    endcase

    // end of line: flush held operator, escape and open word, then summary
    if (in_i.end_of_line) begin
      unique case (step.held)
        HELD_AMP: begin
          step = f_begin_word(step);
          step = f_put_byte(step, CH_AMP);
        end
        HELD_BAR: begin
          step = f_emit(step, KIND_OP, 8'd0, OP_PIPE, 8'd0);
          step.tcnt = f_bump(step.tcnt);
        end
        HELD_GT: begin
          step = f_emit(step, KIND_OP, 8'd0, OP_GT, 8'd0);
          step.tcnt = f_bump(step.tcnt);
        end
        HELD_NONE: ;
      endcase
      step.held = HELD_NONE;
      if (step.in_word && step.esc) begin
        step.esc = 1'b0;
        step = f_put_byte(step, CH_BSLASH);
      end
      if (step.in_word) step = f_end_word(step);
      step = f_emit(step, KIND_DONE, 8'd0, 3'd0, step.tcnt);
      step.in_word = 1'b0;
      step.sq      = 1'b0;
      step.dq      = 1'b0;
      step.esc     = 1'b0;
      step.wlen    = '0;
      step.tcnt    = '0;
    end

    // mark the last result of this character
    if (step.b.count != '0) begin
      step.b.res[RES_IDX_W'(step.b.count - 1'b1)].last_result = 1'b1;
    end
  end

  assign in_i.ready  = !stat_i.full;
  assign cfg_i.ready = 1'b1;
  assign acc         = in_i.valid && in_i.ready;
  assign push_o      = acc && (step.b.count != '0);
  assign bundle_o    = step.b;

  // ---- lexer state and configuration register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q   <= 1'b0;
      sq_q        <= 1'b0;
      dq_q        <= 1'b0;
      esc_q       <= 1'b0;
      wlen_q      <= '0;
      tcnt_q      <= '0;
      held_q      <= HELD_NONE;
      tok_limit_q <= TOK_LIMIT_RST;
    end else begin
      if (acc) begin
        in_word_q <= step.in_word;
        sq_q      <= step.sq;
        dq_q      <= step.dq;
        esc_q     <= step.esc;
        wlen_q    <= step.wlen;
        tcnt_q    <= step.tcnt;
        held_q    <= step.held;
      end
      if (cfg_i.valid && cfg_i.ready) tok_limit_q <= cfg_i.tok_limit;
    end
  end

endmodule

### rtl/scl_fifo.sv
// Short bundle queue between the lexer front and the result sequencer.
// Uses scl_pkg for the bundle and status types.
module scl_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  scl_pkg::bundle_t    push_data_i,
  input  logic                pop_i,
  output scl_pkg::bundle_t    head_o,
  output scl_pkg::fifo_stat_t stat_o
);
  import scl_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bundle_t            mem_q [DEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [CNT_W-1:0]   cnt_q;

  assign head_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign stat_o.empty = (cnt_q == '0);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### rtl/scl_back.sv
// Result sequencer: walks the slots of the head bundle into the output
// register, one result a cycle unless stalled. Uses scl_pkg and scl_if.
module scl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scl_pkg::bundle_t    head_i,
  input  scl_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  scl_out_if.source           out_o
);
  import scl_pkg::*;

  logic [RES_IDX_W-1:0] idx_q;
  logic                 out_valid_q;
  result_t              out_q;
  logic                 advance;
  logic                 take;
  logic                 at_last;

  assign advance = !out_valid_q || out_o.ready;
  assign take    = advance && !stat_i.empty;
  assign at_last = (idx_q == RES_IDX_W'(head_i.count - 1'b1));
  assign pop_o   = take && at_last;

  // slot index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= !stat_i.empty;
      if (take) idx_q <= at_last ? '0 : idx_q + 1'b1;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (take) out_q <= head_i.res[idx_q];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_q.kind;
  assign out_o.word_byte     = out_q.word_byte;
  assign out_o.operator_code = out_q.operator_code;
  assign out_o.token_total   = out_q.token_total;
  assign out_o.last_result   = out_q.last_result;

endmodule

### rtl/scl_checker.sv
// Port-level checks on the lexer result channel, bound to the top level.
// Uses scl_pkg for kind and operator codes.
module scl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic [7:0] word_byte_i,
  input logic [2:0] op_i,
  input logic [7:0] total_i,
  input logic       last_i
);
  import scl_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(word_byte_i) && $stable(op_i) && $stable(total_i) && $stable(last_i))
    else $error("stalled result changed");

  // line done always closes the results of its character
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_DONE |-> last_i)
    else $error("line done not marked last");

  // operator codes stay in range
  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_OP |-> op_i <= OP_LT)
    else $error("operator code out of range");

  // token total only on line done
  a_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != KIND_DONE |-> total_i == 8'd0)
    else $error("token total outside line done");

  // no result while in reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind shell_command_lexer scl_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .kind_i     (out_o.kind),
  .word_byte_i(out_o.word_byte),
  .op_i       (out_o.operator_code),
  .total_i    (out_o.token_total),
  .last_i     (out_o.last_result)
);

### tb/scl_token_checker.sv
`timescale 1ns / 1ps
// Token checker for the command line lexer: follows the character, config and
// token channels, predicts the token stream and compares it word by word.
// Depends on scl_pkg and the channel interfaces of scl_if.sv.
module scl_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  scl_in_if           chars_i,
  scl_cfg_if          cfg_i,
  scl_out_if          tokens_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import scl_pkg::*;

  localparam int TOKEN_CAP  = 128;
  localparam int WORD_CAP   = 1023;
  localparam int REPORT_MAX = 10;

  // lexer state as the predictor sees it
  logic [7:0] max_tok;
  logic       in_word;
  logic       squote;
  logic       dquote;
  logic       escaped;
  held_e      held;
  logic [9:0] word_len;
  logic [7:0] tok_count;

  result_t     line_tokens_q[$];  // results of the character being predicted
  result_t     expected_q[$];     // predicted words not yet seen on the output
  int unsigned mismatch_cnt = 0;
  int unsigned pending_cnt  = 0;

  assign fail_count_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  function automatic void add_token(kind_e k, logic [7:0] b, logic [2:0] op,
                                    logic [7:0] total);
    result_t r;
    if (line_tokens_q.size() < MAX_RESULTS) begin
      r.kind          = k;
      r.word_byte     = b;
      r.operator_code = op;
      r.token_total   = total;
      r.last_result   = 1'b0;
      line_tokens_q.push_back(r);
    end
  endfunction

  // token counter saturates at 255
  function automatic void count_token();
    if (tok_count != 8'hFF) tok_count = tok_count + 8'd1;
  endfunction

  function automatic logic [7:0] token_cap();
    return (max_tok > TOKEN_CAP) ? 8'(TOKEN_CAP) : max_tok;
  endfunction

  function automatic void clear_word();
    in_word  = 1'b0;
    squote   = 1'b0;
    dquote   = 1'b0;
    escaped  = 1'b0;
    word_len = '0;
  endfunction

  function automatic void close_word();
    add_token(KIND_WEND, '0, '0, '0);
    count_token();
    clear_word();
  endfunction

  // length is checked after every appended byte
  function automatic void append_byte(logic [7:0] c);
    add_token(KIND_BYTE, c, '0, '0);
    word_len = word_len + 10'd1;
    if (word_len >= WORD_CAP) close_word();
  endfunction

  function automatic void open_word();
    clear_word();
    in_word = 1'b1;
  endfunction

  function automatic logic is_break(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_SEMI || c == CH_BAR ||
           c == CH_GT || c == CH_LT;
  endfunction

  // byte inside a word; returns 1 when it ended the word unconsumed
  function automatic logic word_char(logic [7:0] c);
    if (escaped) begin
      escaped = 1'b0;
      append_byte(c);
      return 1'b0;
    end
    if (!squote && !dquote && is_break(c)) begin
      close_word();
      return 1'b1;
    end
    if (!squote && c == CH_DQUOTE) dquote = !dquote;
    else if (!dquote && c == CH_SQUOTE) squote = !squote;
    else if (c == CH_BSLASH) escaped = 1'b1;
    else append_byte(c);
    return 1'b0;
  endfunction

  // byte at a token start
  function automatic void start_char(logic [7:0] c);
    if (c == CH_SPACE || c == CH_TAB) return;
    if (tok_count >= token_cap()) return;
    case (c)
      CH_SEMI: begin
        add_token(KIND_OP, '0, OP_SEMI, '0);
        count_token();
      end
      CH_LT: begin
        add_token(KIND_OP, '0, OP_LT, '0);
        count_token();
      end
      CH_AMP: held = HELD_AMP;
      CH_BAR: held = HELD_BAR;
      CH_GT:  held = HELD_GT;
      default: begin
        open_word();
        void'(word_char(c));
      end
    endcase
  endfunction

  function automatic void word_or_start(logic [7:0] c);
    if (in_word) begin
      if (word_char(c)) start_char(c);
    end else begin
      start_char(c);
    end
  endfunction

  function automatic void predict_char(logic [7:0] c, logic eol);
    held_e   h;
    result_t r;
    h    = held;
    held = HELD_NONE;
    line_tokens_q.delete();
    case (h)
      HELD_AMP: begin
        if (c == CH_AMP) begin
          add_token(KIND_OP, '0, OP_AND_AND, '0);
          count_token();
        end else begin
          // lone ampersand starts a word
          open_word();
          append_byte(CH_AMP);
          word_or_start(c);
        end
      end
      HELD_BAR: begin
        if (c == CH_BAR) begin
          add_token(KIND_OP, '0, OP_OR_OR, '0);
          count_token();
        end else begin
          add_token(KIND_OP, '0, OP_PIPE, '0);
          count_token();
          start_char(c);
        end
      end
      HELD_GT: begin
        if (c == CH_GT) begin
          add_token(KIND_OP, '0, OP_APPEND, '0);
          count_token();
        end else begin
          add_token(KIND_OP, '0, OP_GT, '0);
          count_token();
          start_char(c);
        end
      end
      default: word_or_start(c);
    endcase

    // line end flushes held operator, escape and open word
    if (eol) begin
      h    = held;
      held = HELD_NONE;
      case (h)
        HELD_AMP: begin
          open_word();
          append_byte(CH_AMP);
        end
        HELD_BAR: begin
          add_token(KIND_OP, '0, OP_PIPE, '0);
          count_token();
        end
        HELD_GT: begin
          add_token(KIND_OP, '0, OP_GT, '0);
          count_token();
        end
        default: ;
      endcase
      if (in_word && escaped) begin
        escaped = 1'b0;
        append_byte(CH_BSLASH);
      end
      if (in_word) close_word();
      add_token(KIND_DONE, '0, '0, tok_count);
      clear_word();
      tok_count = '0;
    end

    if (line_tokens_q.size() > 0) begin
      r = line_tokens_q.pop_back();
      r.last_result = 1'b1;
      line_tokens_q.push_back(r);
    end
    foreach (line_tokens_q[i]) expected_q.push_back(line_tokens_q[i]);
  endfunction

  function automatic void check_token();
    result_t want;
    if (expected_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $display("%0t: unexpected token word kind %0d byte %02h op %0d total %0d last %0b",
                 $time, tokens_i.kind, tokens_i.word_byte, tokens_i.operator_code,
                 tokens_i.token_total, tokens_i.last_result);
    end else begin
      want = expected_q.pop_front();
      if (want.kind !== tokens_i.kind || want.word_byte !== tokens_i.word_byte ||
          want.operator_code !== tokens_i.operator_code ||
          want.token_total !== tokens_i.token_total ||
          want.last_result !== tokens_i.last_result) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("%0t: mismatch, expected kind %0d byte %02h op %0d total %0d last %0b,%s",
                   $time, want.kind, want.word_byte, want.operator_code, want.token_total,
                   want.last_result, " got:");
        if (mismatch_cnt <= REPORT_MAX)
          $display("    kind %0d byte %02h op %0d total %0d last %0b",
                   tokens_i.kind, tokens_i.word_byte, tokens_i.operator_code,
                   tokens_i.token_total, tokens_i.last_result);
      end
    end
  endfunction

  // sample all three channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tok   = TOK_LIMIT_RST;
      held      = HELD_NONE;
      tok_count = '0;
      clear_word();
      expected_q.delete();
      pending_cnt = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) max_tok = cfg_i.tok_limit;
      if (chars_i.valid && chars_i.ready)
        predict_char(chars_i.character, chars_i.end_of_line);
      if (tokens_i.valid && tokens_i.ready) check_token();
      pending_cnt = expected_q.size();
    end
  end

endmodule

### tb/tb_shell_command_lexer.sv
`timescale 1ns / 1ps
// Testbench top for shell_command_lexer: directed and random command lines,
// token limit changes between phases, idle and stall phases, final verdict.
// Depends on scl_pkg, scl_if.sv, the lexer RTL and scl_token_checker.
module tb_shell_command_lexer;
  import scl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 59;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned line_left      = 0;

  scl_in_if  chars_if ();
  scl_cfg_if cfg_if ();
  scl_out_if tokens_if ();

  shell_command_lexer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (chars_if),
    .cfg_i  (cfg_if),
    .out_o  (tokens_if)
  );

  scl_token_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chars_i      (chars_if),
    .cfg_i        (cfg_if),
    .tokens_i     (tokens_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // token receiver stalls at random
  always @(negedge clk_i) begin
    tokens_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((chars_if.valid && chars_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (tokens_if.valid && tokens_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic eol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      chars_if.valid = 1'b0;
      @(negedge clk_i);
    end
    chars_if.valid       = 1'b1;
    chars_if.character   = c;
    chars_if.end_of_line = eol;
    do @(posedge clk_i); while (!chars_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, logic eol);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eol && (i == s.len() - 1));
  endtask

  // stop sending, wait for all tokens, then let in-flight characters settle
  task automatic wait_drained();
    chars_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0]  cfg_values [NUM_PHASES];
    logic [7:0]  ch;
    int unsigned pick;

    rst_ni               = 1'b0;
    chars_if.valid       = 1'b0;
    chars_if.character   = '0;
    chars_if.end_of_line = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.tok_limit     = '0;
    cfg_values = '{8'd0, 8'd255, 8'd1, TOK_LIMIT_RST, 8'd2,
                   8'($urandom_range(1, 16)), 8'd5, 8'($urandom_range(0, 255))};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed lines at the reset token limit
    send_text("&&||>>;|><", 1'b1);          // every operator, held ones split
    send_text("''\t&", 1'b1);               // empty word, held ampersand at line end
    send_text("\"a\\\"b", 1'b1);            // escape in quotes, quote left open
    send_text("&x\\", 1'b1);                // lone ampersand word, trailing backslash
    send_char(8'h00, 1'b0);                 // zero byte and top byte in a word
    send_char(8'hFF, 1'b0);
    send_char(CH_BAR, 1'b1);                // held pipe at line end
    send_char(CH_GT, 1'b1);                 // held redirect alone on a line

    // random lines, new token limit and idle pattern per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      wait_drained();
      cfg_if.tok_limit = cfg_values[p];
      cfg_if.valid     = 1'b1;
      do @(posedge clk_i); while (!cfg_if.ready);
      @(negedge clk_i);
      cfg_if.valid = 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) ch = 8'($urandom_range(8'h61, 8'h7A));
        else if (pick < 47) ch = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
        else if (pick < 63) begin
          case ($urandom_range(0, 4))
            0: ch = CH_AMP;
            1: ch = CH_BAR;
            2: ch = CH_GT;
            3: ch = CH_SEMI;
            default: ch = CH_LT;
          endcase
        end
        else if (pick < 71) ch = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        else if (pick < 76) ch = CH_BSLASH;
        else ch = 8'($urandom_range(0, 255));
        if (line_left == 0)
          line_left = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 24);
        send_char(ch, line_left == 1);
        line_left--;
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/scl_pkg.sv
rtl/scl_if.sv
rtl/scl_front.sv
rtl/scl_fifo.sv
rtl/scl_back.sv
rtl/shell_command_lexer.sv
rtl/scl_checker.sv
tb/scl_token_checker.sv
tb/tb_shell_command_lexer.sv
